// ----- rtl/tcw_pkg.sv -----
// Shared constants, codes and types of the text cursor cell writer.
package tcw_pkg;

    // Grid limits
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_TAB     = 32;

    // Field and state widths
    localparam int CODE_W     = 8;
    localparam int STYLE_W    = 8;
    localparam int COL_W      = 8;   // cursor column, 0..MAX_COLUMNS
    localparam int ROW_W      = 7;   // cursor row, 0..MAX_ROWS
    localparam int TAB_W      = 6;   // tab width register, count of writes
    localparam int MAXCOL_W   = 7;   // largest column written, 0..MAX_COLUMNS-1
    localparam int CELL_ROW_W = 6;
    localparam int CELL_COL_W = 7;
    localparam int REM_W      = 5;   // column modulo tab width, below MAX_TAB
    localparam int STEP_W     = $clog2(COL_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Character codes
    localparam logic [CODE_W-1:0] CHAR_TAB = 8'd9;
    localparam logic [CODE_W-1:0] CHAR_LF  = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_CR  = 8'd13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH    = 2'd2;

    // Register reset values
    localparam logic [COL_W-1:0] GRID_COLUMNS_RST = 8'd80;
    localparam logic [ROW_W-1:0] GRID_ROWS_RST    = 7'd25;
    localparam logic [TAB_W-1:0] TAB_WIDTH_RST    = 6'd8;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic newline;     // move cursor to the next line
        logic load_item;   // latch the request payload and start the write count
        logic mod_step;    // one step of column modulo tab width
        logic load_count;  // load tab write count from the finished remainder
        logic emit;        // produce one cell write into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_newline;
        logic is_tab;
        logic last;        // one write left for this request
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

// ----- rtl/tcw_if.sv -----
// Channel interfaces: character requests, cell writes and register writes.
interface tcw_char_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CODE_W-1:0]   char_code;
    logic [tcw_pkg::STYLE_W-1:0]  char_style;

    modport source (output valid, output char_code, output char_style, input ready);
    modport sink   (input valid, input char_code, input char_style, output ready);
endinterface

interface tcw_cell_if;
    logic                            valid;
    logic                            ready;
    logic                            write_valid;
    logic [tcw_pkg::CELL_ROW_W-1:0]  cell_row;
    logic [tcw_pkg::CELL_COL_W-1:0]  cell_column;
    logic [tcw_pkg::CODE_W-1:0]      cell_char;
    logic [tcw_pkg::STYLE_W-1:0]     cell_style;
    logic [tcw_pkg::COL_W-1:0]       used_columns;
    logic [tcw_pkg::ROW_W-1:0]       used_rows;
    logic                            last_result;

    modport source (output valid, output write_valid, output cell_row, output cell_column,
                    output cell_char, output cell_style, output used_columns,
                    output used_rows, output last_result, input ready);
    modport sink   (input valid, input write_valid, input cell_row, input cell_column,
                    input cell_char, input cell_style, input used_columns,
                    input used_rows, input last_result, output ready);
endinterface

interface tcw_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]    index;
    logic [tcw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tcw_ctrl.sv -----
// Controller state machine: sequences newline, tab modulo and cell writes.
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd    o_cmd
);

    localparam logic [tcw_pkg::STEP_W-1:0] STEP_LAST = tcw_pkg::STEP_W'(tcw_pkg::COL_W - 1);

    tcw_pkg::t_state             r_state, n_state;
    logic [tcw_pkg::STEP_W-1:0]  r_step, n_step;

    // State and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_status.is_newline) begin
                        o_cmd.newline = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        if (i_status.is_tab) begin
                            n_step  = '0;
                            n_state = tcw_pkg::ST_MOD;
                        end else begin
                            n_state = tcw_pkg::ST_EMIT;
                        end
                    end
                end
            end
            tcw_pkg::ST_MOD: begin
                // one remainder bit per cycle
                o_cmd.mod_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    o_cmd.load_count = 1'b1;
                    n_state          = tcw_pkg::ST_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            tcw_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = tcw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tcw_datapath.sv -----
// Datapath: registers, cursor, maxima, tab modulo unit and output register.
module tcw_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcw_pkg::t_dp_cmd                  i_cmd,
    output tcw_pkg::t_dp_status               o_status,
    input  logic [tcw_pkg::CODE_W-1:0]        i_char_code,
    input  logic [tcw_pkg::STYLE_W-1:0]       i_char_style,
    input  logic                              i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_write_valid,
    output logic [tcw_pkg::CELL_ROW_W-1:0]    o_cell_row,
    output logic [tcw_pkg::CELL_COL_W-1:0]    o_cell_column,
    output logic [tcw_pkg::CODE_W-1:0]        o_cell_char,
    output logic [tcw_pkg::STYLE_W-1:0]       o_cell_style,
    output logic [tcw_pkg::COL_W-1:0]         o_used_columns,
    output logic [tcw_pkg::ROW_W-1:0]         o_used_rows,
    output logic                              o_last_result
);

    localparam logic [tcw_pkg::COL_W-1:0] COLS_MAX = tcw_pkg::COL_W'(tcw_pkg::MAX_COLUMNS);
    localparam logic [tcw_pkg::ROW_W-1:0] ROWS_MAX = tcw_pkg::ROW_W'(tcw_pkg::MAX_ROWS);
    localparam logic [tcw_pkg::TAB_W-1:0] TAB_MAX  = tcw_pkg::TAB_W'(tcw_pkg::MAX_TAB);

    // Configuration registers
    logic [tcw_pkg::COL_W-1:0]      r_grid_columns;
    logic [tcw_pkg::ROW_W-1:0]      r_grid_rows;
    logic [tcw_pkg::TAB_W-1:0]      r_tab_width;

    // Cursor state
    logic [tcw_pkg::COL_W-1:0]      r_col;
    logic [tcw_pkg::ROW_W-1:0]      r_row;
    logic [tcw_pkg::MAXCOL_W-1:0]   r_max_col;
    logic [tcw_pkg::ROW_W-1:0]      r_max_row;

    // Request and tab count
    logic [tcw_pkg::CODE_W-1:0]     r_code;
    logic [tcw_pkg::STYLE_W-1:0]    r_style;
    logic [tcw_pkg::COL_W-1:0]      r_div;
    logic [tcw_pkg::REM_W-1:0]      r_rem;
    logic [tcw_pkg::TAB_W-1:0]      r_left;

    // Output register
    logic                           r_out_valid;
    logic                           r_write_valid;
    logic [tcw_pkg::CELL_ROW_W-1:0] r_cell_row;
    logic [tcw_pkg::CELL_COL_W-1:0] r_cell_column;
    logic [tcw_pkg::CODE_W-1:0]     r_cell_char;
    logic [tcw_pkg::STYLE_W-1:0]    r_cell_style;
    logic [tcw_pkg::COL_W-1:0]      r_used_columns;
    logic [tcw_pkg::ROW_W-1:0]      r_used_rows;
    logic                           r_last_result;

    logic [tcw_pkg::COL_W-1:0]      cols_eff, cols_m1;
    logic [tcw_pkg::ROW_W-1:0]      rows_eff, rows_m1;
    logic [tcw_pkg::TAB_W-1:0]      tab_eff;
    logic [tcw_pkg::ROW_W-1:0]      nl_row;
    logic                           wrap;
    logic [tcw_pkg::COL_W-1:0]      col_w;
    logic [tcw_pkg::ROW_W-1:0]      row_w;
    logic [tcw_pkg::COL_W-1:0]      max_col_wide;
    logic [tcw_pkg::MAXCOL_W-1:0]   n_max_col;
    logic [tcw_pkg::ROW_W-1:0]      n_max_row;
    logic [tcw_pkg::COL_W-1:0]      uc_min;
    logic [tcw_pkg::ROW_W-1:0]      ur_min;
    logic                           cell_in_grid;
    logic [tcw_pkg::TAB_W-1:0]      trial;
    logic [tcw_pkg::REM_W-1:0]      n_rem;
    logic                           out_free;

    // Clamp register values into their legal ranges
    always_comb begin
        if (r_grid_columns == '0) cols_eff = tcw_pkg::COL_W'(1);
        else if (r_grid_columns > COLS_MAX) cols_eff = COLS_MAX;
        else cols_eff = r_grid_columns;

        if (r_grid_rows == '0) rows_eff = tcw_pkg::ROW_W'(1);
        else if (r_grid_rows > ROWS_MAX) rows_eff = ROWS_MAX;
        else rows_eff = r_grid_rows;

        if (r_tab_width == '0) tab_eff = tcw_pkg::TAB_W'(1);
        else if (r_tab_width > TAB_MAX) tab_eff = TAB_MAX;
        else tab_eff = r_tab_width;
    end

    assign cols_m1 = cols_eff - 1'b1;
    assign rows_m1 = rows_eff - 1'b1;

    // Next line row saturates at the row count
    assign nl_row = (r_row < rows_eff) ? r_row + 1'b1 : rows_eff;

    // Cell position after the wrap check
    assign wrap  = (r_col >= cols_eff);
    assign col_w = wrap ? '0 : r_col;
    assign row_w = wrap ? nl_row : r_row;

    // Update the maxima and derive the used size
    always_comb begin
        max_col_wide = (col_w > {1'b0, r_max_col}) ? col_w : {1'b0, r_max_col};
        n_max_col    = max_col_wide[tcw_pkg::MAXCOL_W-1:0];
        n_max_row    = (row_w > r_max_row) ? row_w : r_max_row;
        uc_min       = ({1'b0, n_max_col} < cols_m1) ? {1'b0, n_max_col} : cols_m1;
        ur_min       = (n_max_row < rows_m1) ? n_max_row : rows_m1;
        cell_in_grid = (row_w < rows_eff);
    end

    // Restoring modulo step: shift in one column bit, subtract tab width if it fits
    always_comb begin
        trial = {r_rem, r_div[tcw_pkg::COL_W-1]};
        if (trial >= tab_eff) n_rem = tcw_pkg::REM_W'(trial - tab_eff);
        else n_rem = trial[tcw_pkg::REM_W-1:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= tcw_pkg::GRID_COLUMNS_RST;
            r_grid_rows    <= tcw_pkg::GRID_ROWS_RST;
            r_tab_width    <= tcw_pkg::TAB_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcw_pkg::REG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[tcw_pkg::COL_W-1:0];
                tcw_pkg::REG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[tcw_pkg::ROW_W-1:0];
                tcw_pkg::REG_TAB_WIDTH:    r_tab_width    <= i_cfg_data[tcw_pkg::TAB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cursor and maxima
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_max_col <= '0;
            r_max_row <= '0;
        end else if (i_cmd.newline) begin
            r_col <= '0;
            r_row <= nl_row;
        end else if (i_cmd.emit) begin
            r_col     <= col_w + 1'b1;
            r_row     <= row_w;
            r_max_col <= n_max_col;
            r_max_row <= n_max_row;
        end
    end

    // Request payload, modulo unit and write count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_code  <= i_char_code;
            r_style <= i_char_style;
            r_div   <= r_col;
            r_rem   <= '0;
            r_left  <= tcw_pkg::TAB_W'(1);
        end else begin
            if (i_cmd.mod_step) begin
                r_rem <= n_rem;
                r_div <= r_div << 1;
            end
            if (i_cmd.load_count) begin
                r_left <= tab_eff - {1'b0, n_rem};
            end else if (i_cmd.emit) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // Output register: load on a write, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_write_valid  <= cell_in_grid;
            r_cell_row     <= cell_in_grid ? row_w[tcw_pkg::CELL_ROW_W-1:0] : '0;
            r_cell_column  <= cell_in_grid ? col_w[tcw_pkg::CELL_COL_W-1:0] : '0;
            r_cell_char    <= r_code;
            r_cell_style   <= r_style;
            r_used_columns <= uc_min + 1'b1;
            r_used_rows    <= ur_min + 1'b1;
            r_last_result  <= (r_left == tcw_pkg::TAB_W'(1));
        end
    end

    assign o_status.is_newline = (i_char_code == tcw_pkg::CHAR_LF) ||
                                 (i_char_code == tcw_pkg::CHAR_CR);
    assign o_status.is_tab     = (i_char_code == tcw_pkg::CHAR_TAB);
    assign o_status.last       = (r_left == tcw_pkg::TAB_W'(1));
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_write_valid  = r_write_valid;
    assign o_cell_row     = r_cell_row;
    assign o_cell_column  = r_cell_column;
    assign o_cell_char    = r_cell_char;
    assign o_cell_style   = r_cell_style;
    assign o_used_columns = r_used_columns;
    assign o_used_rows    = r_used_rows;
    assign o_last_result  = r_last_result;

endmodule

// ----- rtl/text_cursor_cell_writer.sv -----
// A printable character is latched when taken; its cell write enters the output register from the emit state once
// that register is free. A newline or carriage return only moves the cursor; a tab first runs the modulo unit, which
// resolves one column bit per cycle, then gives its cell writes. No new request is taken until its last write is made.
// A result waiting in the output register does not hold off the next request.
// Reset is synchronous, active low: cursor and maxima clear to zero, the grid returns to 80 x 25
// with tab stops every 8 columns; no clearing pass follows.
module text_cursor_cell_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_char_if.sink    i_char,
    tcw_cell_if.source  o_cell,
    tcw_cfg_if.sink     i_cfg
);

    tcw_pkg::t_dp_cmd    cmd;
    tcw_pkg::t_dp_status status;
    logic                in_ready;

    // Register writes are always taken
    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = in_ready;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_char_code    (i_char.char_code),
        .i_char_style   (i_char.char_style),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_cell.ready),
        .o_out_valid    (o_cell.valid),
        .o_write_valid  (o_cell.write_valid),
        .o_cell_row     (o_cell.cell_row),
        .o_cell_column  (o_cell.cell_column),
        .o_cell_char    (o_cell.cell_char),
        .o_cell_style   (o_cell.cell_style),
        .o_used_columns (o_cell.used_columns),
        .o_used_rows    (o_cell.used_rows),
        .o_last_result  (o_cell.last_result)
    );

endmodule

// ----- rtl/tcw_checker.sv -----
// Port-level checker of the text cursor cell writer and its bind.
module tcw_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_write_valid,
    input  logic [tcw_pkg::CELL_ROW_W-1:0]    i_cell_row,
    input  logic [tcw_pkg::CELL_COL_W-1:0]    i_cell_column,
    input  logic [tcw_pkg::CODE_W-1:0]        i_cell_char,
    input  logic [tcw_pkg::STYLE_W-1:0]       i_cell_style,
    input  logic [tcw_pkg::COL_W-1:0]         i_used_columns,
    input  logic [tcw_pkg::ROW_W-1:0]         i_used_rows,
    input  logic                              i_last_result
);

    // Hold a stalled cell write
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_write_valid, i_cell_row, i_cell_column, i_cell_char, i_cell_style,
                 i_used_columns, i_used_rows, i_last_result}))
        else $error("cell write changed while stalled");

    // Suppressed writes carry no position
    a_suppressed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_write_valid |-> i_cell_row == '0 && i_cell_column == '0)
        else $error("suppressed write with a nonzero position");

    // A real write lies inside the reported used size
    a_inside_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_valid |->
        {1'b0, i_cell_column} < i_used_columns && {1'b0, i_cell_row} < i_used_rows)
        else $error("cell write outside the used size");

    // Used size stays within the grid limits
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_used_columns != '0 &&
        i_used_columns <= tcw_pkg::COL_W'(tcw_pkg::MAX_COLUMNS) &&
        i_used_rows != '0 && i_used_rows <= tcw_pkg::ROW_W'(tcw_pkg::MAX_ROWS))
        else $error("used size out of range");

    // No new request while a request still has writes to come
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_result |-> !i_in_ready)
        else $error("request taken before the previous one finished");

endmodule

bind text_cursor_cell_writer tcw_checker u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_char.ready),
    .i_out_valid    (o_cell.valid),
    .i_out_ready    (o_cell.ready),
    .i_write_valid  (o_cell.write_valid),
    .i_cell_row     (o_cell.cell_row),
    .i_cell_column  (o_cell.cell_column),
    .i_cell_char    (o_cell.cell_char),
    .i_cell_style   (o_cell.cell_style),
    .i_used_columns (o_cell.used_columns),
    .i_used_rows    (o_cell.used_rows),
    .i_last_result  (o_cell.last_result)
);

// ----- tb/text_cursor_cell_writer_tb.sv -----
// Self-checking testbench of the text cursor cell writer: predicted cell writes vs. the DUT.
`timescale 1ns / 100ps

// One cell write as it leaves the block
typedef struct packed {
    logic       write_valid;
    logic [5:0] row;
    logic [6:0] column;
    logic [7:0] code;
    logic [7:0] style;
    logic [7:0] used_cols;
    logic [6:0] used_rows;
    logic       last;
} t_cell_write;

// Cursor predictor and queue of expected cell writes
class t_cell_write_scoreboard;
    logic [7:0]  grid_columns_reg;
    logic [6:0]  grid_rows_reg;
    logic [5:0]  tab_width_reg;
    logic [7:0]  cursor_col;
    logic [6:0]  cursor_row;
    logic [7:0]  max_col;
    logic [6:0]  max_row;
    t_cell_write expected_cells[$];
    int unsigned failures;

    function new();
        grid_columns_reg = tcw_pkg::GRID_COLUMNS_RST;
        grid_rows_reg    = tcw_pkg::GRID_ROWS_RST;
        tab_width_reg    = tcw_pkg::TAB_WIDTH_RST;
        cursor_col       = '0;
        cursor_row       = '0;
        max_col          = '0;
        max_row          = '0;
        failures         = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [7:0] value);
        case (idx)
            tcw_pkg::REG_GRID_COLUMNS: grid_columns_reg = value;
            tcw_pkg::REG_GRID_ROWS:    grid_rows_reg    = value[6:0];
            tcw_pkg::REG_TAB_WIDTH:    tab_width_reg    = value[5:0];
            default: ;
        endcase
    endfunction

    // Zero acts as one, anything past the limit acts as the limit
    function int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Column 0 of the next row; the row saturates at the row count
    function void advance_line(int unsigned rows);
        cursor_col = '0;
        if (cursor_row < rows) cursor_row = cursor_row + 1'b1;
        else cursor_row = 7'(rows);
    endfunction

    function void note_request(logic [7:0] code, logic [7:0] style);
        int unsigned cols, rows, tw, count, k, uc, ur;
        t_cell_write cw;
        cols = clamp(grid_columns_reg, tcw_pkg::MAX_COLUMNS);
        rows = clamp(grid_rows_reg, tcw_pkg::MAX_ROWS);
        tw   = clamp(tab_width_reg, tcw_pkg::MAX_TAB);
        if (code == tcw_pkg::CHAR_LF || code == tcw_pkg::CHAR_CR) begin
            advance_line(rows);
            return;
        end
        count = (code == tcw_pkg::CHAR_TAB) ? tw - (cursor_col % tw) : 1;
        for (k = 0; k < count; k++) begin
            // wrap before the write, then track the largest position
            if (cursor_col >= cols) advance_line(rows);
            if (cursor_col > max_col) max_col = cursor_col;
            if (cursor_row > max_row) max_row = cursor_row;
            uc = (max_col < cols - 1) ? max_col : cols - 1;
            ur = (max_row < rows - 1) ? max_row : rows - 1;
            cw.write_valid = (cursor_col < cols) && (cursor_row < rows);
            cw.row         = cw.write_valid ? cursor_row[5:0] : '0;
            cw.column      = cw.write_valid ? cursor_col[6:0] : '0;
            cw.code        = code;
            cw.style       = style;
            cw.used_cols   = 8'(uc + 1);
            cw.used_rows   = 7'(ur + 1);
            cw.last        = (k == count - 1);
            expected_cells.push_back(cw);
            cursor_col = cursor_col + 1'b1;
        end
    endfunction

    function string describe(t_cell_write c);
        return $sformatf("wv=%0d row=%0d col=%0d chr=%02h sty=%02h ucol=%0d urow=%0d last=%0d",
                         c.write_valid, c.row, c.column, c.code, c.style,
                         c.used_cols, c.used_rows, c.last);
    endfunction

    function void check_cell(t_cell_write got);
        t_cell_write want;
        if (expected_cells.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected cell write: %s", describe(got));
            return;
        end
        want = expected_cells.pop_front();
        if (got.write_valid !== want.write_valid || got.row !== want.row ||
            got.column !== want.column || got.code !== want.code ||
            got.style !== want.style || got.used_cols !== want.used_cols ||
            got.used_rows !== want.used_rows || got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
                $display("cell write mismatch at %0t", $time);
                $display("  expected: %s", describe(want));
                $display("  actual:   %s", describe(got));
            end
        end
    endfunction
endclass

module text_cursor_cell_writer_tb;

    localparam int unsigned LIMIT        = 4000000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 80;

    logic i_clk;
    logic i_rst_n;

    tcw_char_if char_ch();
    tcw_cell_if cell_ch();
    tcw_cfg_if  cfg_ch();

    t_cell_write_scoreboard writes_sb;
    t_cell_write            seen_cell;
    int unsigned            cycle_count = 0;
    int unsigned            hold_requests = 0;
    bit                     source_gaps_on = 1'b0;
    bit                     sink_stalls_on = 1'b0;

    text_cursor_cell_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_cell  (cell_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register value: zero, past the limit, near the limit, or small
    function automatic logic [7:0] pick_setting(int unsigned small_hi, int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'($urandom_range(hi + 1, 255));
        if (r < 35) return 8'($urandom_range(small_hi + 1, hi));
        return 8'($urandom_range(1, small_hi));
    endfunction

    function automatic logic [7:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 14) return tcw_pkg::CHAR_TAB;
        if (r < 18) return tcw_pkg::CHAR_LF;
        if (r < 22) return tcw_pkg::CHAR_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    // Note requests and register writes, check cell writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                writes_sb.write_register(cfg_ch.index, cfg_ch.data);
            if (char_ch.valid && char_ch.ready)
                writes_sb.note_request(char_ch.char_code, char_ch.char_style);
            if (cell_ch.valid && cell_ch.ready) begin
                seen_cell.write_valid = cell_ch.write_valid;
                seen_cell.row         = cell_ch.cell_row;
                seen_cell.column      = cell_ch.cell_column;
                seen_cell.code        = cell_ch.cell_char;
                seen_cell.style       = cell_ch.cell_style;
                seen_cell.used_cols   = cell_ch.used_columns;
                seen_cell.used_rows   = cell_ch.used_rows;
                seen_cell.last        = cell_ch.last_result;
                writes_sb.check_cell(seen_cell);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("timeout after %0d cycles", LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive ready of the cell write channel: long holds on request, random stalls otherwise
    initial begin : cell_sink
        int unsigned stall_left, hold_left, holds_served;
        stall_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        cell_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                cell_ch.ready <= 1'b0;
            end else begin
                if (stall_left == 0 && sink_stalls_on) stall_left = pick_gap();
                if (stall_left != 0) begin
                    stall_left--;
                    cell_ch.ready <= 1'b0;
                end else begin
                    cell_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Offer one character request; valid stays high for a back-to-back request
    task automatic send_char(input logic [7:0] code, input logic [7:0] style);
        int unsigned gap;
        gap = source_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.char_code  <= code;
        char_ch.char_style <= style;
        do @(posedge i_clk); while (!char_ch.ready);
    endtask

    // Stop sending and wait until every expected cell write has come
    task automatic drain_results();
        char_ch.valid <= 1'b0;
        do @(posedge i_clk); while (writes_sb.expected_cells.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write all three registers back to back; call only while idle
    task automatic set_grid(input logic [7:0] cols, input logic [7:0] rows,
                            input logic [7:0] tab);
        cfg_ch.valid <= 1'b1;
        put_register(tcw_pkg::REG_GRID_COLUMNS, cols);
        put_register(tcw_pkg::REG_GRID_ROWS, rows);
        put_register(tcw_pkg::REG_TAB_WIDTH, tab);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned ph, n;
        writes_sb = new();
        char_ch.valid      <= 1'b0;
        char_ch.char_code  <= '0;
        char_ch.char_style <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= tcw_pkg::REG_GRID_COLUMNS;
        cfg_ch.data        <= '0;
        i_rst_n            <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;

        // Default 80 x 25 grid: extreme bytes, partial and full tab stops, line moves
        send_char(8'h41, 8'h00);
        send_char(8'hFF, 8'hFF);
        send_char(8'h00, 8'hAA);
        send_char(tcw_pkg::CHAR_TAB, 8'h55);
        send_char(tcw_pkg::CHAR_TAB, 8'h0F);
        send_char(tcw_pkg::CHAR_LF, 8'h33);
        send_char(tcw_pkg::CHAR_CR, 8'hCC);
        send_char(8'h80, 8'h01);

        // Narrow grid: fill to the right edge, wrap, then a short tab
        drain_results();
        set_grid(8'd5, 8'd64, 8'd3);
        for (n = 0; n < 5; n++) send_char(8'(8'h30 + n), 8'(8'h10 + n));
        send_char(tcw_pkg::CHAR_TAB, 8'hF0);

        // Shrink the rows under the cursor: line moves saturate, writes fall outside
        drain_results();
        set_grid(8'd5, 8'd4, 8'd3);
        send_char(tcw_pkg::CHAR_LF, 8'h00);
        send_char(8'h78, 8'h3C);
        send_char(tcw_pkg::CHAR_CR, 8'h00);
        send_char(tcw_pkg::CHAR_TAB, 8'hC3);

        // Zero registers act as one
        drain_results();
        set_grid(8'd0, 8'd0, 8'd0);
        send_char(tcw_pkg::CHAR_TAB, 8'h99);
        send_char(8'h20, 8'h66);

        // Registers past their limits: widest grid, 32-column tabs, wrap at column 128
        drain_results();
        set_grid(8'hFF, 8'hFF, 8'hFF);
        send_char(tcw_pkg::CHAR_LF, 8'hFF);
        repeat (4) send_char(tcw_pkg::CHAR_TAB, 8'($urandom_range(0, 255)));
        send_char(8'h7F, 8'h80);

        // Random phases, each under its own grid setting
        for (ph = 0; ph < 6; ph++) begin
            drain_results();
            set_grid(pick_setting(20, tcw_pkg::MAX_COLUMNS), pick_setting(8, tcw_pkg::MAX_ROWS),
                     pick_setting(8, tcw_pkg::MAX_TAB));
            source_gaps_on = (ph % 3 != 0);
            sink_stalls_on = (ph % 2 != 0);
            // hold the receiver off while requests keep coming
            if (ph == 2) hold_requests = hold_requests + 1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // pause the sender until the block has gone quiet
                if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
                send_char(pick_code(), 8'($urandom_range(0, 255)));
            end
        end

        drain_results();
        if (writes_sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_cursor_cell_writer.sv
rtl/tcw_checker.sv
tb/text_cursor_cell_writer_tb.sv
